/* design/adgr_pkg.sv */
`timescale 1ns / 1ps
package adgr_pkg;

    localparam int NUM_ELEMENTS_DEF = 1024;
    localparam int IDX_W            = 10;
    localparam int DATA_W           = 32;
    localparam int ACC_W            = 64;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [DATA_W-1:0] LR_RESET   = 32'd65;
    localparam logic [DATA_W-1:0] STAB_RESET = 32'd1;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    typedef enum logic [0:0] {
        CFG_LEARNING_RATE = 1'b0,
        CFG_STABILIZER    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic               mode;
        logic               in_range;
        logic [IDX_W-1:0]   idx;
        logic               neg;
        logic [DATA_W-1:0]  gmag;
        logic [ACC_W-1:0]   acc;
        logic               sat;
    } t_front_item;

    typedef struct packed {
        logic               valid;
        logic               mode;
        logic               in_range;
        logic [IDX_W-1:0]   idx;
        logic               neg;
        logic               sat;
    } t_back_tag;

endpackage

/* design/adgr_front.sv */
`timescale 1ns / 1ps
module adgr_front
    import adgr_pkg::*;
#(
    parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_mode,
    input  logic [IDX_W-1:0]    i_index,
    input  logic [DATA_W-1:0]   i_gradient,
    input  logic                i_q_full,
    output logic                o_push,
    output t_front_item         o_item
);

    localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

    logic [ACC_W-1:0]   r_acc_mem [NUM_ELEMENTS];
    logic [ACC_W-1:0]   r_rd;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_cnt;

    logic               r_f1_v;
    logic               r_f1_mode;
    logic [IDX_W-1:0]   r_f1_idx;
    logic [DATA_W-1:0]  r_f1_grad;

    logic               r_f2_v;
    logic               r_f2_mode;
    logic [IDX_W-1:0]   r_f2_idx;
    logic               r_f2_inr;
    logic               r_f2_neg;
    logic [DATA_W-1:0]  r_f2_gmag;
    logic [ACC_W-1:0]   r_f2_sq;

    logic               r_last_v;
    logic [IDX_W-1:0]   r_last_idx;
    logic [ACC_W-1:0]   r_last_val;

    logic               w_enable;
    logic               w_wr;
    logic               w_neg;
    logic [DATA_W-1:0]  w_gmag;
    logic [ACC_W-1:0]   w_sq;
    logic               w_inr;
    logic [ACC_W-1:0]   w_acc_old;
    logic [ACC_W:0]     w_sum;
    logic [ACC_W-1:0]   w_acc_new;
    logic               w_sat;

    assign w_enable   = !r_f2_v || !i_q_full;
    assign o_in_ready = w_enable && !r_clr_busy;
    assign o_push     = r_f2_v && !i_q_full;
    assign w_wr       = o_push && r_f2_inr;

    assign w_neg  = r_f1_grad[DATA_W-1];
    assign w_gmag = w_neg ? (~r_f1_grad + 32'd1) : r_f1_grad;
    assign w_sq   = w_gmag * w_gmag;
    assign w_inr  = (17'(r_f1_idx) < 17'(NUM_ELEMENTS));

    always_comb begin
        w_acc_old = (r_last_v && (r_last_idx == r_f2_idx)) ? r_last_val : r_rd;
        w_sum     = {1'b0, w_acc_old} + {1'b0, r_f2_sq};
        w_sat     = 1'b0;
        if (r_f2_mode == MODE_CLEAR) begin
            w_acc_new = '0;
        end else if (w_sum[ACC_W]) begin
            w_acc_new = '1;
            w_sat     = r_f2_inr;
        end else begin
            w_acc_new = w_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        o_item.mode     = r_f2_mode;
        o_item.in_range = r_f2_inr;
        o_item.idx      = r_f2_idx;
        o_item.neg      = r_f2_neg;
        o_item.gmag     = r_f2_gmag;
        o_item.acc      = w_acc_new;
        o_item.sat      = w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v     <= 1'b0;
            r_f2_v     <= 1'b0;
            r_last_v   <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else begin
            if (w_enable) begin
                r_f1_v <= i_in_valid && !r_clr_busy;
                r_f2_v <= r_f1_v;
            end
            if (w_wr) begin
                r_last_v <= 1'b1;
            end
            if (r_clr_busy) begin
                if (r_clr_cnt == AW'(NUM_ELEMENTS - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enable) begin
            r_f1_mode <= i_mode;
            r_f1_idx  <= i_index;
            r_f1_grad <= i_gradient;
            r_f2_mode <= r_f1_mode;
            r_f2_idx  <= r_f1_idx;
            r_f2_inr  <= w_inr;
            r_f2_neg  <= w_neg;
            r_f2_gmag <= w_gmag;
            r_f2_sq   <= w_sq;
        end
        if (w_wr) begin
            r_last_idx <= r_f2_idx;
            r_last_val <= w_acc_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_acc_mem[r_clr_cnt] <= '0;
        end else if (w_wr) begin
            r_acc_mem[AW'(r_f2_idx)] <= w_acc_new;
        end
        if (w_enable) begin
            r_rd <= r_acc_mem[AW'(r_f1_idx)];
        end
    end

endmodule

/* design/adgr_queue.sv */
`timescale 1ns / 1ps
module adgr_queue
    import adgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_front_item i_item,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_front_item o_head
);

    localparam int QW = $clog2(QUEUE_DEPTH);

    t_front_item    r_buf [QUEUE_DEPTH];
    logic [QW-1:0]  r_wr_ptr;
    logic [QW-1:0]  r_rd_ptr;
    logic [QW:0]    r_count;

    assign o_full  = (r_count == (QW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* design/adgr_back.sv */
`timescale 1ns / 1ps
module adgr_back
    import adgr_pkg::*;
#(
    parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [DATA_W-1:0]   i_lr,
    input  logic [DATA_W-1:0]   i_stab,
    input  logic                i_q_empty,
    input  t_front_item         i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [IDX_W-1:0]    o_out_index,
    output logic [DATA_W-1:0]   o_new_value,
    output logic                o_saturated
);

    localparam int AW     = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int SQ_N   = 32;
    localparam int DV_N   = 34;
    localparam logic [DV_N-1:0] MAG_MAX = 34'h2_0000_0000;

    logic               w_en;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_cnt;

    t_back_tag          r_s_tag  [0:SQ_N];
    logic [ACC_W-1:0]   r_s_rem  [0:SQ_N];
    logic [ACC_W-1:0]   r_s_root [0:SQ_N];
    logic [ACC_W-1:0]   r_s_prod [0:SQ_N];

    t_back_tag          r_d_tag  [0:DV_N];
    logic [DATA_W-1:0]  r_d_rem  [0:DV_N];
    logic [DATA_W-1:0]  r_d_root [0:DV_N];
    logic [DV_N-1:0]    r_d_low  [0:DV_N];
    logic [DV_N-1:0]    r_d_q    [0:DV_N];
    logic               r_d_ovf  [0:DV_N];
    logic               r_d_zero [0:DV_N];

    logic [DATA_W-1:0]  r_val_mem [NUM_ELEMENTS];
    t_back_tag          r_v_tag;
    logic [DV_N:0]      r_v_step;
    logic [DATA_W-1:0]  r_v_rd;
    logic               r_vl_v;
    logic [IDX_W-1:0]   r_vl_idx;
    logic [DATA_W-1:0]  r_vl_val;

    logic               r_out_v;
    logic [IDX_W-1:0]   r_out_idx;
    logic [DATA_W-1:0]  r_out_val;
    logic               r_out_sat;

    t_back_tag          w_b0_tag;
    logic [ACC_W:0]     w_rad_sum;
    logic [ACC_W-1:0]   w_rad;
    logic [ACC_W-1:0]   w_prod;
    logic [DATA_W-1:0]  w_root;
    logic [DATA_W+1:0]  w_hi;
    logic [DV_N-1:0]    w_mag;
    logic [DV_N:0]      w_step;
    logic [DATA_W-1:0]  w_v_old;
    logic [DV_N+1:0]    w_nv;
    logic [DATA_W-1:0]  w_nv_sat;
    logic               w_clip;
    logic [DATA_W-1:0]  w_out_val;
    logic               w_out_sat;
    logic               w_wr;

    assign w_en        = !r_out_v || i_out_ready;
    assign o_pop       = w_en && !i_q_empty && !r_clr_busy;
    assign o_out_valid = r_out_v;
    assign o_out_index = r_out_idx;
    assign o_new_value = r_out_val;
    assign o_saturated = r_out_sat;

    // entry: radicand and step numerator
    always_comb begin
        w_b0_tag.valid    = o_pop;
        w_b0_tag.mode     = i_head.mode;
        w_b0_tag.in_range = i_head.in_range;
        w_b0_tag.idx      = i_head.idx;
        w_b0_tag.neg      = i_head.neg;
        w_b0_tag.sat      = i_head.sat;
        w_rad_sum = {1'b0, i_head.acc} + {33'b0, i_stab};
        w_rad     = w_rad_sum[ACC_W] ? '1 : w_rad_sum[ACC_W-1:0];
        w_prod    = i_lr * i_head.gmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_tag[0] <= '0;
        end else if (w_en) begin
            r_s_tag[0] <= w_b0_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_rem[0]  <= w_rad;
            r_s_root[0] <= '0;
            r_s_prod[0] <= w_prod;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 1; k <= SQ_N; k++) begin : g_sqrt
        localparam logic [ACC_W-1:0] BIT = 64'd1 << (62 - 2 * (k - 1));
        logic [ACC_W-1:0] w_try;
        logic             w_ge;

        assign w_try = r_s_root[k-1] + BIT;
        assign w_ge  = (r_s_rem[k-1] >= w_try);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_tag[k] <= '0;
            end else if (w_en) begin
                r_s_tag[k] <= r_s_tag[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_s_rem[k]  <= w_ge ? (r_s_rem[k-1] - w_try) : r_s_rem[k-1];
                r_s_root[k] <= w_ge ? ((r_s_root[k-1] >> 1) + BIT) : (r_s_root[k-1] >> 1);
                r_s_prod[k] <= r_s_prod[k-1];
            end
        end
    end

    // divider setup: quotient clamps above 2^33, so only 34 bits are developed
    assign w_root = r_s_root[SQ_N][DATA_W-1:0];
    assign w_hi   = {4'b0, r_s_prod[SQ_N][ACC_W-1:DV_N]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_tag[0] <= '0;
        end else if (w_en) begin
            r_d_tag[0] <= r_s_tag[SQ_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_rem[0]  <= w_hi[DATA_W-1:0];
            r_d_root[0] <= w_root;
            r_d_low[0]  <= r_s_prod[SQ_N][DV_N-1:0];
            r_d_q[0]    <= '0;
            r_d_ovf[0]  <= (w_hi >= {2'b0, w_root});
            r_d_zero[0] <= (w_root == '0);
        end
    end

    for (genvar j = 1; j <= DV_N; j++) begin : g_div
        localparam int P = DV_N - j;
        logic [DATA_W:0]   w_sh;
        logic              w_ge;
        logic [DATA_W:0]   w_diff;
        logic [DV_N-1:0]   w_q;

        assign w_sh   = {r_d_rem[j-1], r_d_low[j-1][P]};
        assign w_ge   = (w_sh >= {1'b0, r_d_root[j-1]});
        assign w_diff = w_sh - {1'b0, r_d_root[j-1]};

        always_comb begin
            w_q    = r_d_q[j-1];
            w_q[P] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_tag[j] <= '0;
            end else if (w_en) begin
                r_d_tag[j] <= r_d_tag[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d_rem[j]  <= w_ge ? w_diff[DATA_W-1:0] : w_sh[DATA_W-1:0];
                r_d_root[j] <= r_d_root[j-1];
                r_d_low[j]  <= r_d_low[j-1];
                r_d_q[j]    <= w_q;
                r_d_ovf[j]  <= r_d_ovf[j-1];
                r_d_zero[j] <= r_d_zero[j-1];
            end
        end
    end

    always_comb begin
        if (r_d_zero[DV_N]) begin
            w_mag = '0;
        end else if (r_d_ovf[DV_N] || (r_d_q[DV_N] > MAG_MAX)) begin
            w_mag = MAG_MAX;
        end else begin
            w_mag = r_d_q[DV_N];
        end
        w_step = r_d_tag[DV_N].neg ? (~{1'b0, w_mag} + 1'b1) : {1'b0, w_mag};
    end

    // value read-modify-write with bypass of the last write
    always_comb begin
        w_v_old = (r_vl_v && (r_vl_idx == r_v_tag.idx)) ? r_vl_val : r_v_rd;
        w_nv    = {{4{w_v_old[DATA_W-1]}}, w_v_old} + {r_v_step[DV_N], r_v_step};
        w_clip  = (w_nv[DV_N+1:DATA_W-1] != '0) && (w_nv[DV_N+1:DATA_W-1] != '1);
        if (!w_clip) begin
            w_nv_sat = w_nv[DATA_W-1:0];
        end else if (w_nv[DV_N+1]) begin
            w_nv_sat = 32'h8000_0000;
        end else begin
            w_nv_sat = 32'h7FFF_FFFF;
        end
        if (!r_v_tag.in_range || (r_v_tag.mode == MODE_CLEAR)) begin
            w_out_val = '0;
            w_out_sat = 1'b0;
        end else begin
            w_out_val = w_nv_sat;
            w_out_sat = r_v_tag.sat || w_clip;
        end
    end

    assign w_wr = w_en && r_v_tag.valid && r_v_tag.in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_tag    <= '0;
            r_vl_v     <= 1'b0;
            r_out_v    <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else begin
            if (w_en) begin
                r_v_tag <= r_d_tag[DV_N];
                r_out_v <= r_v_tag.valid;
            end
            if (w_wr) begin
                r_vl_v <= 1'b1;
            end
            if (r_clr_busy) begin
                if (r_clr_cnt == AW'(NUM_ELEMENTS - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v_step  <= w_step;
            r_out_idx <= r_v_tag.idx;
            r_out_val <= w_out_val;
            r_out_sat <= w_out_sat;
        end
        if (w_wr) begin
            r_vl_idx <= r_v_tag.idx;
            r_vl_val <= w_out_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_val_mem[r_clr_cnt] <= '0;
        end else if (w_wr) begin
            r_val_mem[AW'(r_v_tag.idx)] <= w_out_val;
        end
        if (w_en) begin
            r_v_rd <= r_val_mem[AW'(r_d_tag[DV_N].idx)];
        end
    end

endmodule

/* design/adagrad_parameter_update.sv */
// Path from request accept to result valid: 2 front stages, queue, 32 square-root
// stages, 35 divider stages, value update. Throughput: one request per cycle unless
// held by output back-pressure, set by the fully pipelined root and divider.
// Reset: synchronous active low; then a clearing pass zeroes both stores, with
// o_in_ready low meanwhile. Config takes writes whenever reset is not asserted.
`timescale 1ns / 1ps
module adagrad_parameter_update
    import adgr_pkg::*;
#(
    parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [DATA_W-1:0]   i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_mode,
    input  logic [IDX_W-1:0]    i_index,
    input  logic [DATA_W-1:0]   i_gradient,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [IDX_W-1:0]    o_out_index,
    output logic [DATA_W-1:0]   o_new_value,
    output logic                o_saturated
);

    logic [DATA_W-1:0]  r_lr;
    logic [DATA_W-1:0]  r_stab;
    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    t_front_item        w_item;
    t_front_item        w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr   <= LR_RESET;
            r_stab <= STAB_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LEARNING_RATE: r_lr   <= i_cfg_data;
                CFG_STABILIZER:    r_stab <= i_cfg_data;
            endcase
        end
    end

    adgr_front #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_mode),
        .i_index    (i_index),
        .i_gradient (i_gradient),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_item     (w_item)
    );

    adgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    adgr_back #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lr        (r_lr),
        .i_stab      (r_stab),
        .i_q_empty   (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_index (o_out_index),
        .o_new_value (o_new_value),
        .o_saturated (o_saturated)
    );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import adgr_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] val;
        logic              sat;
    } t_update_result;

    typedef struct {
        bit                is_cfg;
        t_cfg_idx          reg_sel;
        logic              mode;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
        bit                typed;
        logic [DATA_W-1:0] exp_val;
        logic              exp_sat;
    } t_directed_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [DATA_W-1:0] i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_mode;
    logic [IDX_W-1:0]  i_index;
    logic [DATA_W-1:0] i_gradient;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [IDX_W-1:0]  o_out_index;
    logic [DATA_W-1:0] o_new_value;
    logic              o_saturated;

    adagrad_parameter_update dut (.*);

    logic [ACC_W-1:0]  model_square_sum [NUM_ELEMENTS_DEF];
    logic [DATA_W-1:0] model_value [NUM_ELEMENTS_DEF];
    logic [DATA_W-1:0] model_lr;
    logic [DATA_W-1:0] model_stab;

    t_update_result pending_updates[$];
    int errors = 0;
    int n_req = 0;
    int n_clear = 0;
    int n_sat = 0;
    int n_results = 0;
    bit quiet = 0;
    bit hold_req = 0;

    initial i_clk = 0;

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    initial begin
        #50_000_000;
        $display("adagrad_parameter_update verification failed");
        $finish;
    end

    function automatic logic [ACC_W-1:0] int_sqrt(input logic [ACC_W-1:0] x);
        logic [ACC_W-1:0] rem;
        logic [ACC_W-1:0] root;
        logic [ACC_W-1:0] b;
        rem = x;
        root = 0;
        b = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic t_update_result predict_update(input logic mode,
            input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] grad);
        t_update_result r;
        logic              neg;
        logic [DATA_W:0]   gmag;
        logic [ACC_W-1:0]  sq;
        logic [ACC_W:0]    sum;
        logic [ACC_W-1:0]  acc;
        logic [ACC_W-1:0]  rad;
        logic [ACC_W-1:0]  root;
        logic [ACC_W-1:0]  mag;
        longint            v;
        longint            nv;
        r.idx = idx;
        r.val = 0;
        r.sat = 0;
        if (mode == MODE_CLEAR) begin
            model_square_sum[idx] = 0;
            model_value[idx] = 0;
            return r;
        end
        neg = grad[31];
        gmag = neg ? (33'h1_0000_0000 - {1'b0, grad}) : {1'b0, grad};
        sq = 64'(gmag) * 64'(gmag);
        sum = {1'b0, model_square_sum[idx]} + {1'b0, sq};
        if (sum[ACC_W]) begin
            acc = '1;
            r.sat = 1;
        end else begin
            acc = sum[ACC_W-1:0];
        end
        model_square_sum[idx] = acc;
        sum = {1'b0, acc} + 65'(model_stab);
        rad = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
        root = int_sqrt(rad);
        mag = 0;
        if (root != 0) mag = (64'(model_lr) * 64'(gmag)) / root;
        if (mag > (64'd1 << 33)) mag = 64'd1 << 33;
        v = longint'(signed'(model_value[idx]));
        nv = neg ? v - longint'(mag) : v + longint'(mag);
        if (nv > 64'sd2147483647) begin
            nv = 64'sd2147483647;
            r.sat = 1;
        end else if (nv < -64'sd2147483648) begin
            nv = -64'sd2147483648;
            r.sat = 1;
        end
        model_value[idx] = nv[31:0];
        r.val = nv[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_update_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_updates.size() == 0) begin
                report_mismatch("unexpected result index", o_out_index, 0);
            end else begin
                e = pending_updates.pop_front();
                if (o_out_index !== e.idx) report_mismatch("out_index", o_out_index, e.idx);
                if (o_new_value !== e.val) report_mismatch("new_value", o_new_value, e.val);
                if (o_saturated !== e.sat) report_mismatch("saturated", o_saturated, e.sat);
                if (e.sat) n_sat++;
            end
        end
    end

    initial begin
        int burst;
        burst = 0;
        i_out_ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 0;
                repeat (300) @(negedge i_clk);
                hold_req = 0;
            end else if (quiet) begin
                i_out_ready <= 1;
            end else if (burst > 0) begin
                i_out_ready <= 0;
                burst--;
            end else if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 14) - 1;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= 1;
            end
        end
    end

    task automatic cfg_write(input t_cfg_idx sel, input logic [DATA_W-1:0] data);
        i_in_valid <= 0;
        wait (pending_updates.size() == 0);
        @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= sel;
        i_cfg_data <= data;
        if (sel == CFG_LEARNING_RATE) model_lr = data;
        else model_stab = data;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic send_request(input logic mode, input logic [IDX_W-1:0] idx,
            input logic [DATA_W-1:0] grad, input bit typed,
            input logic [DATA_W-1:0] exp_val, input logic exp_sat);
        t_update_result r;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_mode <= mode;
        i_index <= idx;
        i_gradient <= grad;
        do @(posedge i_clk); while (!o_in_ready);
        r = predict_update(mode, idx, grad);
        if (typed) begin
            r.val = exp_val;
            r.sat = exp_sat;
        end
        pending_updates.push_back(r);
        n_req++;
        if (mode == MODE_CLEAR) n_clear++;
        @(negedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_gradient();
        unique case ($urandom_range(0, 5))
            0: return $urandom_range(0, 65535);
            1: return -$urandom_range(0, 65535);
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    t_directed_row directed [21] = '{
        '{0, CFG_LEARNING_RATE, MODE_UPDATE, 10'd0, 32'h0000_0000, 1, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_CLEAR, 10'd3, 32'h1234_5678, 1, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_UPDATE, 10'd1023, 32'h7fff_ffff, 0, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_UPDATE, 10'd1023, 32'h8000_0000, 0, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_UPDATE, 10'd2, 32'h0001_0000, 0, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_UPDATE, 10'd2, 32'hffff_0000, 0, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_UPDATE, 10'd7, 32'h8000_0000, 0, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_UPDATE, 10'd7, 32'h8000_0000, 0, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_UPDATE, 10'd7, 32'h8000_0000, 0, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_UPDATE, 10'd7, 32'h8000_0000, 0, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_CLEAR, 10'd7, 32'hffff_ffff, 1, 32'h0, 1'b0},
        '{1, CFG_LEARNING_RATE, MODE_UPDATE, 10'd0, 32'hffff_ffff, 0, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_UPDATE, 10'd8, 32'h7fff_ffff, 0, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_UPDATE, 10'd9, 32'h8000_0000, 0, 32'h0, 1'b0},
        '{1, CFG_STABILIZER, MODE_UPDATE, 10'd0, 32'h0000_0000, 0, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_UPDATE, 10'd10, 32'h0000_0000, 1, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_CLEAR, 10'd1023, 32'h0, 1, 32'h0, 1'b0},
        '{1, CFG_LEARNING_RATE, MODE_UPDATE, 10'd0, 32'h0000_0000, 0, 32'h0, 1'b0},
        '{0, CFG_LEARNING_RATE, MODE_UPDATE, 10'd11, 32'h1234_5678, 1, 32'h0, 1'b0},
        '{1, CFG_LEARNING_RATE, MODE_UPDATE, 10'd0, 32'd65, 0, 32'h0, 1'b0},
        '{1, CFG_STABILIZER, MODE_UPDATE, 10'd0, 32'd1, 0, 32'h0, 1'b0}
    };

    initial begin
        logic [IDX_W-1:0] idx;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = CFG_LEARNING_RATE;
        i_cfg_data = 0;
        i_in_valid = 0;
        i_mode = MODE_UPDATE;
        i_index = 0;
        i_gradient = 0;
        model_lr = LR_RESET;
        model_stab = STAB_RESET;
        foreach (model_value[k]) begin
            model_value[k] = 0;
            model_square_sum[k] = 0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1;

        foreach (directed[k]) begin
            if (directed[k].is_cfg)
                cfg_write(directed[k].reg_sel, directed[k].data);
            else
                send_request(directed[k].mode, directed[k].idx, directed[k].data,
                             directed[k].typed, directed[k].exp_val, directed[k].exp_sat);
        end

        for (int phase = 0; phase < 7; phase++) begin
            unique case (phase)
                1: begin
                    cfg_write(CFG_LEARNING_RATE, 32'hffff_ffff);
                    cfg_write(CFG_STABILIZER, 32'h0);
                end
                2: begin
                    cfg_write(CFG_LEARNING_RATE, 32'h0);
                    cfg_write(CFG_STABILIZER, 32'hffff_ffff);
                end
                3, 4: begin
                    cfg_write(CFG_LEARNING_RATE, $urandom);
                    cfg_write(CFG_STABILIZER, $urandom);
                end
                5, 6: begin
                    cfg_write(CFG_LEARNING_RATE, 32'h0001_0000 >> $urandom_range(0, 8));
                    cfg_write(CFG_STABILIZER, $urandom_range(0, 1000));
                end
                default: ;
            endcase
            if (phase == 6) quiet = 1;
            for (int n = 0; n < 135; n++) begin
                if (phase == 2 && n == 20) hold_req = 1;
                if (phase == 4 && n == 60) begin
                    i_in_valid <= 0;
                    wait (pending_updates.size() == 0);
                end
                idx = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 15)) : 10'($urandom);
                send_request(($urandom_range(0, 9) == 0) ? MODE_CLEAR : MODE_UPDATE,
                             idx, rand_gradient(), 0, 0, 0);
            end
        end
        i_in_valid <= 0;

        wait (pending_updates.size() == 0);
        repeat (80) @(posedge i_clk);
        $display("requests sent %0d (clears %0d), results checked %0d, saturated %0d",
                 n_req, n_clear, n_results, n_sat);
        $display("covered: reset config, rate and stabilizer extremes, random settings");
        if (errors == 0 && pending_updates.size() == 0)
            $display("adagrad_parameter_update verification clean");
        else
            $display("adagrad_parameter_update verification failed");
        $finish;
    end
endmodule
